### hw/rtl/dabd_pkg.sv
// Shared constants, register codes and types for the anchor box decoder.
`default_nettype none
package dabd_pkg;

  localparam int BOX_FIELDS = 4;
  localparam int BOX_IDX_W = $clog2(BOX_FIELDS);
  localparam int VALUE_W = 17;
  localparam int SCORE_W = 16;
  localparam int LABEL_W = 8;
  localparam int CORNER_W = 17;
  localparam int POS_W = 9;
  localparam int CLASS_W = 8;
  localparam int PAD_W = 15;
  localparam int SCALE_W = 22;
  localparam int SIZE_W = 13;
  // Twice the padded center plus or minus the size, in units of 1/32 pixel.
  localparam int N_W = 20;
  // Product of 1/32 units and the Q6.16 scale is in units of 2^-21.
  localparam int PROD_SHIFT = 17;
  localparam int FRAC_BITS = 4;

  localparam int DEFAULT_COORD_WIDTH = 16;
  localparam int DEFAULT_SCORE_WIDTH = 16;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int STREAM_IN_W = 24;
  localparam int STREAM_OUT_W = 96;

  localparam logic [2:0] REG_CLASS_COUNT     = 3'd0;
  localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_PAD_X           = 3'd2;
  localparam logic [2:0] REG_PAD_Y           = 3'd3;
  localparam logic [2:0] REG_SCALE_RATIO     = 3'd4;
  localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd5;
  localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd6;

  localparam logic [CLASS_W-1:0] RST_CLASS_COUNT     = 8'd80;
  localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd16384;
  localparam logic [PAD_W-1:0]   RST_PAD             = 15'd0;
  localparam logic [SCALE_W-1:0] RST_SCALE_RATIO     = 22'd65536;
  localparam logic [SIZE_W-1:0]  RST_IMAGE_SIZE      = 13'd640;

  typedef struct packed {
    logic [CLASS_W-1:0] class_count;
    logic [SCORE_W-1:0] score_threshold;
    logic [PAD_W-1:0]   pad_x;
    logic [PAD_W-1:0]   pad_y;
    logic [SCALE_W-1:0] scale_ratio;
    logic [SIZE_W-1:0]  image_width;
    logic [SIZE_W-1:0]  image_height;
  } cfg_t;

  // A detection that passed the threshold, waiting for the corner stage.
  typedef struct packed {
    logic [LABEL_W-1:0]    label;
    logic [SCORE_W-1:0]    score;
    logic signed [N_W-1:0] n_left;
    logic signed [N_W-1:0] n_top;
    logic signed [N_W-1:0] n_right;
    logic signed [N_W-1:0] n_bottom;
  } cand_t;

endpackage
`default_nettype wire

### hw/rtl/dabd_cfg_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module dabd_cfg_regs
  import dabd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.class_count     <= RST_CLASS_COUNT;
      cfg.score_threshold <= RST_SCORE_THRESHOLD;
      cfg.pad_x           <= RST_PAD;
      cfg.pad_y           <= RST_PAD;
      cfg.scale_ratio     <= RST_SCALE_RATIO;
      cfg.image_width     <= RST_IMAGE_SIZE;
      cfg.image_height    <= RST_IMAGE_SIZE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CLASS_COUNT:     cfg.class_count     <= pwdata[CLASS_W-1:0];
        REG_SCORE_THRESHOLD: cfg.score_threshold <= pwdata[SCORE_W-1:0];
        REG_PAD_X:           cfg.pad_x           <= pwdata[PAD_W-1:0];
        REG_PAD_Y:           cfg.pad_y           <= pwdata[PAD_W-1:0];
        REG_SCALE_RATIO:     cfg.scale_ratio     <= pwdata[SCALE_W-1:0];
        REG_IMAGE_WIDTH:     cfg.image_width     <= pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT:    cfg.image_height    <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CLASS_COUNT:     prdata = CFG_DATA_W'(cfg.class_count);
      REG_SCORE_THRESHOLD: prdata = CFG_DATA_W'(cfg.score_threshold);
      REG_PAD_X:           prdata = CFG_DATA_W'(cfg.pad_x);
      REG_PAD_Y:           prdata = CFG_DATA_W'(cfg.pad_y);
      REG_SCALE_RATIO:     prdata = CFG_DATA_W'(cfg.scale_ratio);
      REG_IMAGE_WIDTH:     prdata = CFG_DATA_W'(cfg.image_width);
      REG_IMAGE_HEIGHT:    prdata = CFG_DATA_W'(cfg.image_height);
      default:             prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/dabd_anchor_track.sv
// Per-anchor tracking: box capture, running argmax and the candidate register.
`default_nettype none
module dabd_anchor_track
  import dabd_pkg::*;
#(
  parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH,
  parameter int SCORE_WIDTH = DEFAULT_SCORE_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               accept,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               cand_take,
  output logic                    cand_valid,
  output cand_t                   cand
);

  // Box values never need more bits than the input field carries.
  localparam int BOX_W = (COORD_WIDTH < VALUE_W) ? COORD_WIDTH : VALUE_W;
  localparam logic [SCORE_W-1:0] SCORE_MAX = (SCORE_WIDTH >= SCORE_W) ? {SCORE_W{1'b1}} :
                                             SCORE_W'((32'd1 << SCORE_WIDTH) - 32'd1);

  logic signed [BOX_W-1:0] box [BOX_FIELDS];
  logic signed [BOX_W-1:0] box_in;
  logic [POS_W-1:0]        pos;
  logic [SCORE_W-1:0]      best_score;
  logic [LABEL_W-1:0]      best_label;

  logic [SCORE_W-1:0]      score_in;
  logic [CLASS_W-1:0]      cc_eff;
  logic [POS_W-1:0]        last_pos;
  logic [POS_W-1:0]        cls;
  logic                    is_box;
  logic                    is_last;
  logic                    take;
  logic [SCORE_W-1:0]      best_score_next;
  logic [LABEL_W-1:0]      best_label_next;
  logic                    fire;
  logic signed [N_W-1:0]   twice_x;
  logic signed [N_W-1:0]   twice_y;
  logic signed [N_W-1:0]   size_w;
  logic signed [N_W-1:0]   size_h;

  // Saturate a box value to the signed coordinate range.
  if (COORD_WIDTH < VALUE_W) begin : g_clamp
    logic all_ones;
    logic all_zeros;
    assign all_ones  = &value[VALUE_W-1:COORD_WIDTH-1];
    assign all_zeros = ~|value[VALUE_W-1:COORD_WIDTH-1];
    always_comb begin
      if (all_ones || all_zeros) begin
        box_in = value[BOX_W-1:0];
      end else if (value[VALUE_W-1]) begin
        box_in = {1'b1, {(BOX_W-1){1'b0}}};
      end else begin
        box_in = {1'b0, {(BOX_W-1){1'b1}}};
      end
    end
  end else begin : g_no_clamp
    assign box_in = value[BOX_W-1:0];
  end

  always_comb begin
    if (value[VALUE_W-1]) begin
      score_in = '0;
    end else if (value[SCORE_W-1:0] > SCORE_MAX) begin
      score_in = SCORE_MAX;
    end else begin
      score_in = value[SCORE_W-1:0];
    end
  end

  assign cc_eff   = (cfg.class_count == '0) ? CLASS_W'(1) : cfg.class_count;
  assign last_pos = POS_W'(BOX_FIELDS - 1) + POS_W'(cc_eff);
  assign is_box   = pos < POS_W'(BOX_FIELDS);
  // A lowered class count ends the anchor at the first position past the new end.
  assign is_last  = pos >= last_pos;
  assign cls      = pos - POS_W'(BOX_FIELDS);
  assign take     = (cls == '0) || (score_in > best_score);

  assign best_score_next = take ? score_in : best_score;
  assign best_label_next = take ? cls[LABEL_W-1:0] : best_label;
  assign fire = accept && !is_box && is_last && (best_score_next > cfg.score_threshold);

  // Corner numerators in units of 1/32 pixel: 2*(c - pad) -+ size.
  assign twice_x = (N_W'(box[0]) - N_W'($signed({1'b0, cfg.pad_x}))) <<< 1;
  assign twice_y = (N_W'(box[1]) - N_W'($signed({1'b0, cfg.pad_y}))) <<< 1;
  assign size_w  = N_W'(box[2]);
  assign size_h  = N_W'(box[3]);

  always_ff @(posedge clk) begin
    if (accept && is_box) begin
      box[pos[BOX_IDX_W-1:0]] <= box_in;
    end
    if (fire) begin
      cand.label    <= best_label_next;
      cand.score    <= best_score_next;
      cand.n_left   <= twice_x - size_w;
      cand.n_top    <= twice_y - size_h;
      cand.n_right  <= twice_x + size_w;
      cand.n_bottom <= twice_y + size_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      best_score <= '0;
      best_label <= '0;
      cand_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (is_box) begin
          pos <= pos + POS_W'(1);
        end else begin
          best_score <= best_score_next;
          best_label <= best_label_next;
          pos        <= is_last ? '0 : pos + POS_W'(1);
        end
      end
      if (fire) begin
        cand_valid <= 1'b1;
      end else if (cand_take) begin
        cand_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/dabd_corner.sv
// One corner: scale the numerator into image pixels, truncate and clamp.
`default_nettype none
module dabd_corner
  import dabd_pkg::*;
(
  input  wire logic signed [N_W-1:0]     n,
  input  wire logic        [SCALE_W-1:0] scale_ratio,
  input  wire logic        [SIZE_W-1:0]  size_px,
  output logic             [CORNER_W-1:0] corner
);

  localparam int PROD_W = N_W - 1 + SCALE_W;
  localparam int Q_W = PROD_W - PROD_SHIFT;

  logic [PROD_W-1:0]   prod;
  logic [Q_W-1:0]      q;
  logic [CORNER_W-1:0] upper;
  logic                positive;

  assign positive = !n[N_W-1] && (n != '0);
  assign prod     = PROD_W'(n[N_W-2:0]) * PROD_W'(scale_ratio);
  assign q        = prod[PROD_W-1:PROD_SHIFT];
  assign upper    = {size_px, {FRAC_BITS{1'b0}}};

  always_comb begin
    if (!positive) begin
      corner = '0;
    end else if (q > Q_W'(upper)) begin
      corner = upper;
    end else begin
      corner = q[CORNER_W-1:0];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/detection_anchor_box_decoder_unit.sv
// Top level of the streaming anchor box decoder with argmax.
`default_nettype none
// The block takes one detector value per cycle on the slave stream, anchor after
// anchor: center x, center y, width, height (signed Q12.4), then class_count scores
// (Q0.16). Box capture and the running argmax update in the accept cycle, so the
// input sustains one value per clock while s_tready is high. When the last score of
// an anchor beats the threshold, the candidate is registered, its four corners each
// go through one 19x22 multiply and clamp combinationally, and the result is
// registered into the output register that drives the master stream. The candidate
// register and the output register act as a two-entry buffer; s_tready falls only
// while both hold a result that the sink has not taken.
module detection_anchor_box_decoder_unit
  import dabd_pkg::*;
#(
  parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH,
  parameter int SCORE_WIDTH = DEFAULT_SCORE_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [STREAM_IN_W-1:0]  s_tdata,   // [16:0] value
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic      [STREAM_OUT_W-1:0] m_tdata,   // label, score, left, top, right, bottom
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [CFG_ADDR_W-1:0]   paddr,
  input  wire logic [CFG_DATA_W-1:0]   pwdata,
  output logic      [CFG_DATA_W-1:0]   prdata,
  output logic                         pready
);

  cfg_t                cfg;
  cand_t               cand;
  logic                cand_valid;
  logic                out_stall;
  logic                cand_take;
  logic                accept;
  logic [CORNER_W-1:0] left;
  logic [CORNER_W-1:0] top;
  logic [CORNER_W-1:0] right;
  logic [CORNER_W-1:0] bottom;

  assign out_stall = m_tvalid && !m_tready;
  assign cand_take = !out_stall;
  assign s_tready  = !cand_valid || cand_take;
  assign accept    = s_tvalid && s_tready;

  dabd_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dabd_anchor_track #(
    .COORD_WIDTH (COORD_WIDTH),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_anchor_track (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .value      (s_tdata[VALUE_W-1:0]),
    .cand_take  (cand_take),
    .cand_valid (cand_valid),
    .cand       (cand)
  );

  dabd_corner u_corner_left (
    .n (cand.n_left), .scale_ratio (cfg.scale_ratio), .size_px (cfg.image_width),
    .corner (left)
  );

  dabd_corner u_corner_top (
    .n (cand.n_top), .scale_ratio (cfg.scale_ratio), .size_px (cfg.image_height),
    .corner (top)
  );

  dabd_corner u_corner_right (
    .n (cand.n_right), .scale_ratio (cfg.scale_ratio), .size_px (cfg.image_width),
    .corner (right)
  );

  dabd_corner u_corner_bottom (
    .n (cand.n_bottom), .scale_ratio (cfg.scale_ratio), .size_px (cfg.image_height),
    .corner (bottom)
  );

  always_ff @(posedge clk) begin
    if (cand_take && cand_valid) begin
      m_tdata <= {{(STREAM_OUT_W - LABEL_W - SCORE_W - 4 * CORNER_W){1'b0}},
                  bottom, right, top, left, cand.score, cand.label};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cand_take) begin
      m_tvalid <= cand_valid;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/dabd_checker.sv
// Port-level checks for the anchor box decoder, bound to the top level.
`default_nettype none
module dabd_checker
  import dabd_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    s_tvalid,
  input wire logic                    s_tready,
  input wire logic                    m_tvalid,
  input wire logic                    m_tready,
  input wire logic [STREAM_OUT_W-1:0] m_tdata
);

  // Reset leaves no result pending on the master side.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A result the sink has not taken keeps its contents.
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // A reported score beats a threshold of at least zero, so it cannot be zero.
  a_score_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[LABEL_W +: SCORE_W] != '0))
    else $error("result with zero score");

  // A fresh result follows the transaction of its last score through the candidate and output registers.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a matching input transaction");

endmodule

bind detection_anchor_box_decoder_unit dabd_checker u_dabd_checker (.*);
`default_nettype wire
